FILE: sv/bda_pkg.sv
// Shared constants for the binary to decimal ASCII converter.
// Used by the conversion pipeline and the top level. No dependencies.
package bda_pkg;

  // width of one BCD digit
  localparam int DIGIT_W = 4;

  // ASCII code of '0' at the width of the output character
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // number of double dabble register stages
  localparam int STAGES = 4;

  // log10(2) as a ratio, used to size the digit count at elaboration
  localparam int LOG2_NUM = 30103;
  localparam int LOG2_DEN = 100000;

endpackage

FILE: sv/bda_dabble_pipe.sv
// Pipelined double dabble converter: binary number in, packed BCD digits out.
// Depends on bda_pkg for the digit width and the stage count.
module bda_dabble_pipe #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_DIGITS = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [VALUE_BITS-1:0]                  in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [MAX_DIGITS*bda_pkg::DIGIT_W-1:0] out_bcd
);

  localparam int BPS   = (VALUE_BITS + bda_pkg::STAGES - 1) / bda_pkg::STAGES;
  localparam int PAD_W = BPS * bda_pkg::STAGES;
  localparam int BCD_W = MAX_DIGITS * bda_pkg::DIGIT_W;

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [PAD_W-1:0] bin_t;

  logic [bda_pkg::STAGES:0] vld;
  logic [bda_pkg::STAGES:0] rdy;
  bcd_t                     bcd [bda_pkg::STAGES+1];
  bin_t                     bin [bda_pkg::STAGES+1];

  // One stage worth of shift-add-3 steps on the BCD word
  function automatic bcd_t dabble_bcd(input bcd_t b_in, input bin_t v_in);
    bcd_t b;
    bin_t v;
    b = b_in;
    v = v_in;
    for (int s = 0; s < BPS; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (b[d*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] >= 4'd5) begin
          b[d*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
            b[d*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], v[PAD_W-1]};
      v = {v[PAD_W-2:0], 1'b0};
    end
    return b;
  endfunction

  // Ready ripples back from the output: a stage takes a beat when empty or moving on
  assign rdy[bda_pkg::STAGES] = !vld[bda_pkg::STAGES] || out_ready;
  for (genvar k = 0; k < bda_pkg::STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[bda_pkg::STAGES];
  assign out_bcd   = bcd[bda_pkg::STAGES];

  // Advance the valid bits of the input register and the conversion stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k <= bda_pkg::STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Input register pads the number with leading zeros and clears the BCD word;
  // conversion stages then take BPS bits each
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      bcd[0] <= '0;
      bin[0] <= PAD_W'(in_value);
    end
    for (int k = 1; k <= bda_pkg::STAGES; k++) begin
      if (rdy[k]) begin
        bcd[k] <= dabble_bcd(bcd[k-1], bin[k-1]);
        bin[k] <= bin[k-1] << BPS;
      end
    end
  end

endmodule

FILE: sv/binary_to_decimal_ascii_core.sv
// Binary to decimal ASCII converter, top level.
// Depends on bda_pkg and bda_dabble_pipe.
//
// Usage:
//   Slave channel s_*: one beat per number; s_tdata holds the number in its
//   low VALUE_BITS bits. Master channel m_*: one beat per decimal digit,
//   most significant first, leading zeros dropped; zero gives a single '0'.
//   m_tlast marks the least significant digit of each number.
// Path: an accepted number passes the input register, four double dabble
//   stages and the output sequencer before its first digit shows on m_*.
// Throughput: one digit per cycle on m_* while m_tready is high; a number
//   has 1 to 5 digits at 16 bits, and the output sequencer walks the
//   digits of one number at a time. The conversion pipeline takes a new
//   number every cycle while it has room.
// Reset: rst, synchronous, empties the pipeline and the output sequencer;
//   nothing else is held between numbers.
// Stall: while m_tready is low the current digit is held; the pipeline
//   fills behind it and then drops s_tready. Nothing is lost or repeated.
module binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // fields from bit 0: number[VALUE_BITS-1:0], zero fill
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // fields from bit 0: digit_char[5:0], zero fill
  output logic [7:0]                           m_tdata,
  output logic                                 m_tlast
);

  localparam int MAX_DIGITS = (VALUE_BITS * bda_pkg::LOG2_NUM) / bda_pkg::LOG2_DEN + 1;
  localparam int BCD_W      = MAX_DIGITS * bda_pkg::DIGIT_W;
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  logic                            p_valid;
  logic                            p_ready;
  logic [BCD_W-1:0]                p_bcd;
  logic [BCD_W-1:0]                bcd;
  logic [IDX_W-1:0]                idx;
  logic [IDX_W-1:0]                top_idx;
  logic                            busy;
  logic                            out_beat;
  logic                            load;
  logic [bda_pkg::DIGIT_W-1:0]     cur_digit;

  bda_dabble_pipe #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata[VALUE_BITS-1:0]),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_bcd   (p_bcd)
  );

  // Find the most significant non-zero digit; zero keeps digit 0
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (p_bcd[d*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] != '0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  // Take the next number once the last digit of the current one leaves
  assign out_beat = m_tvalid && m_tready;
  assign p_ready  = !busy || (out_beat && idx == '0);
  assign load     = p_valid && p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= top_idx;
    end else if (out_beat) begin
      if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= p_bcd;
    end
  end

  // Present the selected digit as ASCII
  assign cur_digit = bcd[idx*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W];
  assign m_tvalid  = busy;
  assign m_tdata   = {2'b00, bda_pkg::ASCII_ZERO + {2'b00, cur_digit}};
  assign m_tlast   = (idx == '0);

`ifndef SYNTH
  // First digit of a number is never a suppressed zero
  a_lead_digit: assert property (@(posedge clk) disable iff (rst)
    load |=> (m_tdata[3:0] != 4'd0 || m_tlast))
    else $error("leading zero digit emitted");

  // Digit pointer stays inside the BCD word
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (32'(idx) < MAX_DIGITS))
    else $error("digit index out of range");

  // A new number is loaded only when the sequencer is free or finishing
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load && busy) |-> (out_beat && m_tlast))
    else $error("sequencer overwritten mid-number");
`endif

endmodule
